>>> rtl/unaligned_cap_access_emulator_defines.svh
// assertion macros used by the emulator controller
`ifndef UNALIGNED_CAP_ACCESS_EMULATOR_DEFINES_SVH
`define UNALIGNED_CAP_ACCESS_EMULATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UCAE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ucae assertion failed");

// consequent must hold in the cycle after the antecedent
`define UCAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucae assertion failed");

`endif

>>> rtl/ucae_pkg.sv
// shared types, codes and helpers of the unaligned capability access emulator
package ucae_pkg;

   localparam int REQ_W  = 648;
   localparam int RSP_W  = 136;
   localparam int USER_W = 3;
   localparam int IN_W   = 641;

   localparam logic [2:0] KIND_BYTE = 3'd0;
   localparam logic [2:0] KIND_REG  = 3'd1;
   localparam logic [2:0] KIND_LINK = 3'd2;
   localparam logic [2:0] KIND_PC   = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;

   localparam logic [5:0]  OP_STORE  = 6'h3a;
   localparam logic [5:0]  OP_LOAD   = 6'h32;
   localparam logic [5:0]  OP_CJUMP  = 6'h12;
   localparam logic [5:0]  OP_BEQ    = 6'h04;
   localparam logic [5:0]  OP_BNE    = 6'h05;
   localparam logic [5:0]  OP_REGIMM = 6'h01;
   localparam logic [5:0]  OP_BLEZ   = 6'h06;
   localparam logic [5:0]  OP_BGTZ   = 6'h07;
   localparam logic [10:0] SUB_CJR   = 11'h7ff;
   localparam logic [10:0] SUB_CJALR = 11'h33f;

   localparam logic [4:0] RI_BLTZ = 5'd0;
   localparam logic [4:0] RI_BGEZ = 5'd1;

   typedef struct packed {
      logic       capture;
      logic       ea1;
      logic       ea2;
      logic       br;
      logic       emit;
      logic [2:0] kind;
   } ucae_cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       op_store;
      logic       op_load;
      logic       load_wr;
      logic       link_en;
      logic       fail;
      logic [2:0] nb_m1;
   } ucae_sts_type;

   function automatic logic gpr_zero(input logic [4:0] i);
      return (i == 5'd0) || (i == 5'd26) || (i == 5'd27);
   endfunction

   function automatic logic cap_valid(input logic [4:0] i);
      return (i != 5'd0) && (i <= 5'd26);
   endfunction

endpackage

>>> rtl/ucae_datapath.sv
// decode, address, branch resolution and result register of the emulator
module ucae_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ucae_pkg::REQ_W-1:0]  req_tdata,
   input  ucae_pkg::ucae_cmd_type      cmd,
   output ucae_pkg::ucae_sts_type      sts,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ucae_pkg::RSP_W-1:0]  rsp_tdata,
   output logic [ucae_pkg::USER_W-1:0] rsp_tuser,
   output logic                        rsp_tlast
);
   import ucae_pkg::*;

   logic [IN_W-1:0] in_ff, in_in;
   logic [63:0] ea_ff, ea_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] next_ff, next_in;
   logic [63:0] link_ff, link_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_addr_ff, rsp_addr_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [4:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] fi, bi;
   logic        slot;
   logic [63:0] pc, base, idx, sv, ld, rs, rt, ja, jb;
   logic [5:0]  op, bop;
   logic [4:0]  rd, cb, rti, rsi, ra, rb;
   logic [7:0]  off8;
   logic        sgn;
   logic [1:0]  t;
   logic [2:0]  nb_m1;
   logic [63:0] off_s;
   logic [63:0] ld_val;
   logic [63:0] rsu, rtu;
   logic        neg, eq, zero, take, br_bad, link_en;
   logic [17:0] imm_p1;
   logic [63:0] pc4, pc8, pcb, next_c;

   assign fi   = in_ff[31:0];
   assign bi   = in_ff[63:32];
   assign slot = in_ff[64];
   assign pc   = in_ff[128:65];
   assign base = in_ff[192:129];
   assign idx  = in_ff[256:193];
   assign sv   = in_ff[320:257];
   assign ld   = in_ff[384:321];
   assign rs   = in_ff[448:385];
   assign rt   = in_ff[512:449];
   assign ja   = in_ff[576:513];
   assign jb   = in_ff[640:577];

   assign op   = fi[31:26];
   assign rd   = fi[25:21];
   assign cb   = fi[20:16];
   assign rti  = fi[15:11];
   assign off8 = fi[10:3];
   assign sgn  = fi[2];
   assign t    = fi[1:0];

   assign bop = bi[31:26];
   assign rsi = bi[25:21];
   assign ra  = bi[20:16];
   assign rb  = bi[15:11];

   always_comb begin
      unique case (t)
         2'd0: nb_m1 = 3'd0;
         2'd1: nb_m1 = 3'd1;
         2'd2: nb_m1 = 3'd3;
         default: nb_m1 = 3'd7;
      endcase
   end

   // low t bits of the scaled offset are zero, so or-ing in nb-1 adds it
   assign off_s = ({{56{off8[7]}}, off8} << t) | {61'd0, nb_m1};

   always_comb begin
      unique case (t)
         2'd0: ld_val = {{56{sgn & ld[63]}}, ld[63:56]};
         2'd1: ld_val = {{48{sgn & ld[63]}}, ld[63:48]};
         2'd2: ld_val = {{32{sgn & ld[63]}}, ld[63:32]};
         default: ld_val = ld;
      endcase
   end

   assign rsu    = gpr_zero(rsi) ? 64'd0 : rs;
   assign rtu    = gpr_zero(ra) ? 64'd0 : rt;
   assign neg    = rsu[63];
   assign eq     = (rsu == rtu);
   assign zero   = (rsu == 64'd0);
   assign imm_p1 = {{2{bi[15]}}, bi[15:0]} + 18'd1;
   assign pc4    = pc + 64'd4;
   assign pc8    = pc + 64'd8;
   assign pcb    = pc + {{44{imm_p1[17]}}, imm_p1, 2'b00};

   always_comb begin
      next_c  = pc4;
      br_bad  = 1'b0;
      link_en = 1'b0;
      take    = 1'b0;
      if (slot) begin
         if (bop == OP_CJUMP) begin
            priority if (bi[10:0] == SUB_CJR) begin
               next_c = cap_valid(ra) ? ja : 64'd0;
            end else if (bi[10:0] == SUB_CJALR) begin
               link_en = cap_valid(ra);
               if (cap_valid(ra) && (ra == rb)) next_c = pc8;
               else next_c = cap_valid(rb) ? jb : 64'd0;
            end else begin
               br_bad = 1'b1;
            end
         end else begin
            priority if (bop == OP_BEQ) take = eq;
            else if (bop == OP_BNE) take = !eq;
            else if ((bop == OP_REGIMM) && (ra == RI_BLTZ)) take = neg;
            else if ((bop == OP_REGIMM) && (ra == RI_BGEZ)) take = !neg;
            else if ((bop == OP_BLEZ) && (ra == 5'd0)) take = neg || zero;
            else if ((bop == OP_BGTZ) && (ra == 5'd0)) take = !neg && !zero;
            else br_bad = 1'b1;
            next_c = take ? pcb : pc8;
         end
      end
   end

   always_comb begin
      in_in   = in_ff;
      ea_in   = ea_ff;
      val_in  = val_ff;
      next_in = next_ff;
      link_in = link_ff;
      if (cmd.capture) in_in = req_tdata[IN_W-1:0];
      if (cmd.ea1) begin
         ea_in  = (cap_valid(cb) ? base : 64'd0) + off_s;
         val_in = gpr_zero(rd) ? 64'd0 : sv;
      end
      if (cmd.ea2) ea_in = ea_ff + (gpr_zero(rti) ? 64'd0 : idx);
      if (cmd.br) begin
         next_in = next_c;
         link_in = pc8;
      end
      // store bytes go out highest address first, lowest byte first
      if (cmd.emit && (cmd.kind == KIND_BYTE)) begin
         ea_in  = ea_ff - 64'd1;
         val_in = val_ff >> 8;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.kind;
         rsp_addr_in  = 64'd0;
         rsp_data_in  = 64'd0;
         rsp_idx_in   = 5'd0;
         rsp_last_in  = 1'b0;
         unique case (cmd.kind)
            KIND_BYTE: begin
               rsp_addr_in = ea_ff;
               rsp_data_in = {56'd0, val_ff[7:0]};
            end
            KIND_REG: begin
               rsp_data_in = ld_val;
               rsp_idx_in  = rd;
            end
            KIND_LINK: begin
               rsp_data_in = link_ff;
               rsp_idx_in  = ra;
            end
            KIND_PC: begin
               rsp_addr_in = next_ff;
               rsp_last_in = 1'b1;
            end
            default: rsp_last_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff       <= in_in;
      ea_ff       <= ea_in;
      val_ff      <= val_in;
      next_ff     <= next_in;
      link_ff     <= link_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.op_store = (op == OP_STORE);
   assign sts.op_load  = (op == OP_LOAD);
   assign sts.load_wr  = !gpr_zero(rd);
   assign sts.link_en  = link_en;
   assign sts.fail     = br_bad || ((op != OP_STORE) && (op != OP_LOAD));
   assign sts.nb_m1    = nb_m1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_idx_ff, rsp_data_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/ucae_controller.sv
// sequencing state machine of the emulator
`include "unaligned_cap_access_emulator_defines.svh"

module ucae_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ucae_pkg::ucae_sts_type sts,
   output ucae_pkg::ucae_cmd_type cmd
);
   import ucae_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EA1   = 3'd1;
   localparam logic [2:0] S_EA2   = 3'd2;
   localparam logic [2:0] S_BR    = 3'd3;
   localparam logic [2:0] S_STORE = 3'd4;
   localparam logic [2:0] S_LOAD  = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] after_mem;

   assign after_mem = sts.link_en ? S_LINK : S_FIN;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EA1;
            end
         end
         S_EA1: begin
            cmd.ea1  = 1'b1;
            state_in = S_EA2;
         end
         S_EA2: begin
            cmd.ea2  = 1'b1;
            state_in = S_BR;
         end
         S_BR: begin
            cmd.br = 1'b1;
            cnt_in = sts.nb_m1;
            priority if (sts.op_store) state_in = S_STORE;
            else if (sts.op_load && sts.load_wr) state_in = S_LOAD;
            else if (sts.op_load) state_in = after_mem;
            else state_in = S_FIN;
         end
         S_STORE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_BYTE;
               if (cnt_ff == 3'd0) state_in = after_mem;
               else cnt_in = cnt_ff - 3'd1;
            end
         end
         S_LOAD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_REG;
               state_in = after_mem;
            end
         end
         S_LINK: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_LINK;
               state_in = S_FIN;
            end
         end
         default: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = sts.fail ? KIND_ERR : KIND_PC;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `UCAE_ASSERT_NOW(a_emit_slot_free, clock, reset, cmd.emit, sts.out_free)
   `UCAE_ASSERT_NOW(a_byte_only_store, clock, reset, cmd.emit && (cmd.kind == KIND_BYTE), sts.op_store)
   `UCAE_ASSERT_NEXT(a_store_ends, clock, reset, (state_ff == S_STORE) && cmd.emit && (cnt_ff == 3'd0), (state_ff == S_LINK) || (state_ff == S_FIN))

endmodule

>>> rtl/unaligned_cap_access_emulator.sv
// top level of the unaligned capability load/store emulator
// Takes one trapped capability load or store per transaction on req_ with the register
// values and memory bytes already fetched, and returns its results on rsp_: big-endian
// byte writes for a store, a register write for a load, an optional capability link write,
// then a next-pc result, or an error where the opcode or delay-slot branch is unknown;
// the final result carries rsp_tlast. An instruction passes through the capture, address and
// branch resolution states, then emits one result per cycle while the output register is free;
// req_tready rises again once the final result is loaded into the output register, which is
// the single slot that paces the result stream.
module unaligned_cap_access_emulator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // fault_instr, branch_instr, in_delay_slot, exc_pc, base_cursor, index_value,
   // store_value, load_data, branch_rs_value, branch_rt_value, jump_cap_a, jump_cap_b
   input  logic [ucae_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // address, data, reg_index
   output logic [ucae_pkg::RSP_W-1:0]  rsp_tdata,
   // kind
   output logic [ucae_pkg::USER_W-1:0] rsp_tuser,
   output logic                        rsp_tlast
);
   import ucae_pkg::*;

   ucae_cmd_type cmd;
   ucae_sts_type sts;

   ucae_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ucae_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> bench/unaligned_cap_access_emulator_checker.sv
// checker that predicts the emulator results from each request and compares them
module unaligned_cap_access_emulator_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [ucae_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [ucae_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic [ucae_pkg::USER_W-1:0] rsp_tuser,
   input  logic                        rsp_tlast,
   output int                          mismatch_count,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ucae_pkg::*;

   localparam logic [4:0] GPR_ZERO = 5'd0;
   localparam logic [4:0] GPR_K0   = 5'd26;
   localparam logic [4:0] GPR_K1   = 5'd27;
   localparam logic [4:0] CAP_NULL = 5'd0;
   localparam logic [4:0] CAP_TOP  = 5'd26;

   // request layout, the last field declared here in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [63:0] jump_cap_b;
      logic [63:0] jump_cap_a;
      logic [63:0] branch_rt_value;
      logic [63:0] branch_rs_value;
      logic [63:0] load_data;
      logic [63:0] store_value;
      logic [63:0] index_value;
      logic [63:0] base_cursor;
      logic [63:0] exc_pc;
      logic        in_delay_slot;
      logic [31:0] branch_instr;
      logic [31:0] fault_instr;
   } access_req_t;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] address;
      logic [63:0] data;
      logic [4:0]  reg_index;
      logic        last;
   } effect_t;

   effect_t expected_effects[$];
   effect_t observed;
   effect_t oldest;
   int      fail_total = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic logic gpr_is_zero(input logic [4:0] i);
      return (i == GPR_ZERO) || (i == GPR_K0) || (i == GPR_K1);
   endfunction

   function automatic logic cap_usable(input logic [4:0] i);
      return (i != CAP_NULL) && (i <= CAP_TOP);
   endfunction

   function automatic logic [63:0] read_gpr(input logic [4:0] i, input logic [63:0] v);
      return gpr_is_zero(i) ? 64'd0 : v;
   endfunction

   function automatic logic [63:0] read_cap(input logic [4:0] i, input logic [63:0] v);
      return cap_usable(i) ? v : 64'd0;
   endfunction

   function automatic void add_effect(input logic [2:0] kind, input logic [63:0] address,
                                      input logic [63:0] data, input logic [4:0] idx,
                                      input logic last);
      effect_t e;
      e.kind      = kind;
      e.address   = address;
      e.data      = data;
      e.reg_index = idx;
      e.last      = last;
      expected_effects.push_back(e);
   endfunction

   function automatic void predict_effects(input access_req_t r);
      logic [5:0]  op;
      logic [5:0]  bop;
      logic [1:0]  t;
      logic [4:0]  rd, cb, rt, ra, rb;
      logic [31:0] br;
      logic [63:0] off, ea, v, next, link, imm, rsv, rtv;
      logic        take;
      logic        known;
      int          nb;
      op  = r.fault_instr[31:26];
      rd  = r.fault_instr[25:21];
      cb  = r.fault_instr[20:16];
      rt  = r.fault_instr[15:11];
      t   = r.fault_instr[1:0];
      off = {{56{r.fault_instr[10]}}, r.fault_instr[10:3]} << t;
      ea  = read_cap(cb, r.base_cursor) + off + read_gpr(rt, r.index_value);
      nb  = 1 << t;
      if (op == OP_STORE) begin
         v = read_gpr(rd, r.store_value);
         // big-endian: the least significant byte lands at the highest address
         for (int k = nb - 1; k >= 0; k--) begin
            add_effect(KIND_BYTE, ea + 64'(k), {56'd0, v[7:0]}, 5'd0, 1'b0);
            v = v >> 8;
         end
      end else if (op == OP_LOAD) begin
         v = r.load_data >> (64 - 8 * nb);
         if (r.fault_instr[2] && nb < 8 && v[8 * nb - 1])
            v = v | (~64'd0 << (8 * nb));
         if (!gpr_is_zero(rd))
            add_effect(KIND_REG, 64'd0, v, rd, 1'b0);
      end else begin
         add_effect(KIND_ERR, 64'd0, 64'd0, 5'd0, 1'b1);
         return;
      end

      next  = r.exc_pc + 64'd4;
      known = 1'b1;
      if (r.in_delay_slot) begin
         br  = r.branch_instr;
         bop = br[31:26];
         ra  = br[20:16];
         rb  = br[15:11];
         if (bop == OP_CJUMP) begin
            if (br[10:0] == SUB_CJR) begin
               next = read_cap(ra, r.jump_cap_a);
            end else if (br[10:0] == SUB_CJALR) begin
               link = r.exc_pc + 64'd8;
               next = read_cap(rb, r.jump_cap_b);
               if (cap_usable(ra)) begin
                  add_effect(KIND_LINK, 64'd0, link, ra, 1'b0);
                  if (ra == rb)
                     next = link;
               end
            end else begin
               known = 1'b0;
            end
         end else begin
            imm  = {{48{br[15]}}, br[15:0]};
            rsv  = read_gpr(br[25:21], r.branch_rs_value);
            rtv  = read_gpr(ra, r.branch_rt_value);
            take = 1'b0;
            if (bop == OP_BEQ)
               take = (rsv == rtv);
            else if (bop == OP_BNE)
               take = (rsv != rtv);
            else if (bop == OP_REGIMM && ra == RI_BLTZ)
               take = rsv[63];
            else if (bop == OP_REGIMM && ra == RI_BGEZ)
               take = !rsv[63];
            else if (bop == OP_BLEZ && ra == 5'd0)
               take = rsv[63] || (rsv == 64'd0);
            else if (bop == OP_BGTZ && ra == 5'd0)
               take = !rsv[63] && (rsv != 64'd0);
            else
               known = 1'b0;
            next = take ? r.exc_pc + 64'd4 + (imm << 2) : r.exc_pc + 64'd8;
         end
      end
      if (known)
         add_effect(KIND_PC, next, 64'd0, 5'd0, 1'b1);
      else
         add_effect(KIND_ERR, 64'd0, 64'd0, 5'd0, 1'b1);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_effects(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            observed = {rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64], rsp_tdata[132:128],
                        rsp_tlast};
            if (expected_effects.size() == 0) begin
               if (fail_total < 10)
                  $display("unexpected result: kind %0d address %h data %h index %0d last %0b",
                           observed.kind, observed.address, observed.data, observed.reg_index,
                           observed.last);
               fail_total++;
            end else begin
               oldest = expected_effects.pop_front();
               if (observed !== oldest) begin
                  if (fail_total < 10) begin
                     $display({"result mismatch: expected kind %0d address %h data %h",
                               " index %0d last %0b"},
                              oldest.kind, oldest.address, oldest.data, oldest.reg_index,
                              oldest.last);
                     $display({"                 actual   kind %0d address %h data %h",
                               " index %0d last %0b"},
                              observed.kind, observed.address, observed.data,
                              observed.reg_index, observed.last);
                  end
                  fail_total++;
               end
            end
         end
      end
      mismatch_count <= fail_total;
      outstanding    <= expected_effects.size();
   end

endmodule

>>> bench/testbench.sv
// top of the emulator bench: clock, reset, request stimulus, result back-pressure, verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ucae_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 236;
   localparam int QUIET_FROM   = 200;

   typedef struct packed {
      logic [6:0]  pad;
      logic [63:0] jump_cap_b;
      logic [63:0] jump_cap_a;
      logic [63:0] branch_rt_value;
      logic [63:0] branch_rs_value;
      logic [63:0] load_data;
      logic [63:0] store_value;
      logic [63:0] index_value;
      logic [63:0] base_cursor;
      logic [63:0] exc_pc;
      logic        in_delay_slot;
      logic [31:0] branch_instr;
      logic [31:0] fault_instr;
   } access_req_t;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [USER_W-1:0] rsp_tuser;
   logic              rsp_tlast;
   logic              quiet      = 1'b0;
   int                stall_left = 0;
   int                cycle_count = 0;
   int                mismatches;
   int                outstanding;

   localparam logic [63:0] PAT  = 64'h0123_4567_89ab_cdef;
   localparam logic [63:0] NEG  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] PC0  = 64'h0000_0000_0040_1000;

   unaligned_cap_access_emulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   unaligned_cap_access_emulator_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // result back-pressure in random bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [63:0] random_word64();
      case ($urandom_range(0, 11))
         0:       return 64'd0;
         1:       return ONES;
         2:       return NEG;
         3:       return ~NEG;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] mem_word(input logic [5:0] op, input logic [4:0] rd,
                                            input logic [4:0] cb, input logic [4:0] rt,
                                            input logic [7:0] off, input logic sgn,
                                            input logic [1:0] t);
      return {op, rd, cb, rt, off, sgn, t};
   endfunction

   function automatic logic [31:0] branch_word(input logic [5:0] op, input logic [4:0] rs,
                                               input logic [4:0] ra, input logic [15:0] low);
      return {op, rs, ra, low};
   endfunction

   function automatic logic [31:0] cjump_word(input logic [4:0] ra, input logic [4:0] rb,
                                              input logic [10:0] sub);
      return branch_word(OP_CJUMP, 5'd0, ra, {rb, sub});
   endfunction

   function automatic logic [31:0] random_branch();
      logic [31:0] br;
      br = $urandom;
      case ($urandom_range(0, 9))
         0: br[31:26] = OP_BEQ;
         1: br[31:26] = OP_BNE;
         2: begin
            br[31:26] = OP_REGIMM;
            if ($urandom_range(0, 4) != 0)
               br[20:16] = ($urandom_range(0, 1) != 0) ? RI_BGEZ : RI_BLTZ;
         end
         3: begin
            br[31:26] = OP_BLEZ;
            if ($urandom_range(0, 4) != 0) br[20:16] = 5'd0;
         end
         4: begin
            br[31:26] = OP_BGTZ;
            if ($urandom_range(0, 4) != 0) br[20:16] = 5'd0;
         end
         5, 6: begin
            br[31:26] = OP_CJUMP;
            br[10:0]  = SUB_CJR;
         end
         7, 8: begin
            br[31:26] = OP_CJUMP;
            br[10:0]  = SUB_CJALR;
            // same capability for link and target
            if ($urandom_range(0, 2) == 0) br[15:11] = br[20:16];
         end
         default: ;
      endcase
      return br;
   endfunction

   function automatic access_req_t random_access();
      access_req_t a;
      int          pick;
      a = '0;
      a.fault_instr = $urandom;
      pick = $urandom_range(0, 19);
      if (pick < 9)
         a.fault_instr[31:26] = OP_STORE;
      else if (pick < 18)
         a.fault_instr[31:26] = OP_LOAD;
      a.branch_instr    = random_branch();
      a.in_delay_slot   = ($urandom_range(0, 3) != 0);
      a.exc_pc          = random_word64();
      a.base_cursor     = random_word64();
      a.index_value     = random_word64();
      a.store_value     = random_word64();
      a.load_data       = random_word64();
      a.branch_rs_value = random_word64();
      a.branch_rt_value = ($urandom_range(0, 2) == 0) ? a.branch_rs_value : random_word64();
      a.jump_cap_a      = random_word64();
      a.jump_cap_b      = random_word64();
      return a;
   endfunction

   task automatic send_access(input access_req_t a);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tdata  <= a;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_directed(input logic [31:0] fault, input logic [31:0] branch,
                                input logic slot, input logic [63:0] pc,
                                input logic [63:0] rs_val, input logic [63:0] rt_val,
                                input logic [63:0] mem);
      access_req_t a;
      a = random_access();
      a.fault_instr     = fault;
      a.branch_instr    = branch;
      a.in_delay_slot   = slot;
      a.exc_pc          = pc;
      a.branch_rs_value = rs_val;
      a.branch_rt_value = rt_val;
      a.load_data       = mem;
      send_access(a);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stores of every width, offset extremes, zero registers and capabilities
      send_directed(mem_word(OP_STORE, 5'd5, 5'd3, 5'd7, 8'h7f, 1'b0, 2'd3), 32'd0, 1'b0,
                    PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd1, 5'd0, 5'd0, 8'h80, 1'b0, 2'd0), 32'd0, 1'b0,
                    64'hffff_ffff_ffff_fffc, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd26, 5'd26, 5'd27, 8'hff, 1'b1, 2'd1),
                    branch_word(OP_BEQ, 5'd3, 5'd4, 16'h8000), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd31, 5'd27, 5'd31, 8'h01, 1'b0, 2'd2),
                    branch_word(OP_BNE, 5'd3, 5'd4, 16'h7fff), 1'b1, PC0, PAT, ~PAT, PAT);
      // loads: one-byte signed and unsigned, every width sign-extended
      send_directed(mem_word(OP_LOAD, 5'd2, 5'd1, 5'd2, 8'h00, 1'b1, 2'd0),
                    branch_word(OP_REGIMM, 5'd7, RI_BLTZ, 16'h0010), 1'b1, PC0, NEG, PAT,
                    64'hfe00_0000_0000_0001);
      send_directed(mem_word(OP_LOAD, 5'd2, 5'd1, 5'd2, 8'h00, 1'b0, 2'd0),
                    branch_word(OP_REGIMM, 5'd7, RI_BGEZ, 16'hfff0), 1'b1, PC0, PAT, PAT, ONES);
      send_directed(mem_word(OP_LOAD, 5'd3, 5'd4, 5'd5, 8'hf0, 1'b1, 2'd1),
                    branch_word(OP_BLEZ, 5'd0, 5'd0, 16'h0100), 1'b1, PC0, PAT, PAT,
                    64'h8001_2345_6789_abcd);
      send_directed(mem_word(OP_LOAD, 5'd4, 5'd4, 5'd5, 8'h10, 1'b1, 2'd2),
                    branch_word(OP_BGTZ, 5'd9, 5'd0, 16'h0004), 1'b1, PC0, 64'd1, PAT,
                    64'h8000_0001_ffff_ffff);
      send_directed(mem_word(OP_LOAD, 5'd31, 5'd4, 5'd5, 8'h80, 1'b1, 2'd3),
                    branch_word(OP_BGTZ, 5'd9, 5'd5, 16'h0004), 1'b1, PC0, 64'd1, PAT, NEG);
      send_directed(mem_word(OP_LOAD, 5'd0, 5'd8, 5'd9, 8'h3c, 1'b0, 2'd3), 32'd0, 1'b0,
                    ONES, PAT, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd27, 5'd8, 5'd9, 8'h3c, 1'b1, 2'd2),
                    branch_word(OP_REGIMM, 5'd7, 5'd2, 16'h0010), 1'b1, PC0, NEG, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd8, 5'd8, 5'd9, 8'h00, 1'b0, 2'd3), 32'd0, 1'b0,
                    PC0, PAT, PAT, ONES);
      // unknown opcodes
      send_directed(32'd0, 32'd0, 1'b0, PC0, PAT, PAT, PAT);
      send_directed({6'h3f, 26'h3ff_ffff}, cjump_word(5'd9, 5'd2, SUB_CJR), 1'b1, PC0,
                    PAT, PAT, PAT);
      // capability jumps, with and without link, through zero and invalid slots, and an unknown sub-op
      send_directed(mem_word(OP_STORE, 5'd6, 5'd2, 5'd3, 8'h08, 1'b0, 2'd1),
                    cjump_word(5'd9, 5'd2, SUB_CJR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd6, 5'd2, 5'd3, 8'h08, 1'b0, 2'd1),
                    cjump_word(5'd0, 5'd2, SUB_CJR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd6, 5'd2, 5'd3, 8'h08, 1'b1, 2'd2),
                    cjump_word(5'd27, 5'd2, SUB_CJR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd6, 5'd2, 5'd3, 8'hf8, 1'b0, 2'd3),
                    cjump_word(5'd4, 5'd6, SUB_CJALR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd6, 5'd2, 5'd3, 8'hf8, 1'b0, 2'd0),
                    cjump_word(5'd12, 5'd12, SUB_CJALR), 1'b1, ONES, PAT, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd6, 5'd2, 5'd3, 8'h04, 1'b0, 2'd2),
                    cjump_word(5'd0, 5'd3, SUB_CJALR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd6, 5'd2, 5'd3, 8'h04, 1'b1, 2'd1),
                    cjump_word(5'd31, 5'd31, SUB_CJALR), 1'b1, PC0, PAT, PAT, PAT);
      send_directed(mem_word(OP_STORE, 5'd6, 5'd2, 5'd3, 8'h04, 1'b0, 2'd1),
                    cjump_word(5'd4, 5'd6, 11'h000), 1'b1, PC0, PAT, PAT, PAT);
      // branches not taken
      send_directed(mem_word(OP_STORE, 5'd6, 5'd2, 5'd3, 8'h04, 1'b0, 2'd0),
                    branch_word(OP_BEQ, 5'd3, 5'd4, 16'h0040), 1'b1, PC0, PAT, ~PAT, PAT);
      send_directed(mem_word(OP_LOAD, 5'd6, 5'd2, 5'd3, 8'h04, 1'b0, 2'd3),
                    branch_word(OP_BNE, 5'd3, 5'd4, 16'h0040), 1'b1, PC0, PAT, PAT, PAT);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == QUIET_FROM) quiet <= 1'b1;
         send_access(random_access());
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
